// ===== design/trope_pkg.sv =====
// Shared types and constants for the tree rotary position embedding block.
`timescale 1ns / 1ps
`default_nettype none
package trope_pkg;

  typedef enum logic [1:0] {
    CMD_TABLE = 2'd0,
    CMD_TOKEN = 2'd1,
    CMD_ELEM  = 2'd2,
    CMD_END   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_ROTARY_PAIRS  = 1'b0,
    REG_MAX_POSITIONS = 1'b1
  } cfg_reg_t;

  localparam int TRIG_W    = 16;
  localparam int PAIRS_W   = 7;
  localparam int MAXPOS_W  = 11;
  localparam int OUTPOS_W  = 10;
  localparam logic [PAIRS_W-1:0]  PAIRS_RST  = 7'd64;
  localparam logic [MAXPOS_W-1:0] MAXPOS_RST = 11'd1024;

  // result queue
  localparam int RSP_DEPTH = 8;
  localparam int RSP_AW    = 3;
  localparam int RSP_PW    = 4;

endpackage : trope_pkg
`default_nettype wire

// ===== design/tree_rotary_position_embedding.sv =====
// Top level: tree-position rotary embedding with sine/cosine memory and result queue.
// Pipeline: decode and memory read, multiply, round/saturate into the queue; results
//   are then held in an 8-entry result queue.
// Throughput: one request per cycle while req_stall is low (queue not full); each element
//   needs a single read of the sine/cosine memory and the ancestor position memory has one read port.
// Reset: synchronous, clears pipeline valids, queue pointers, base and token
//   position, overflow flag, and restores rotary_pairs 64, max_positions 1024.
`timescale 1ns / 1ps
`default_nettype none
module tree_rotary_position_embedding #(
  parameter int POS_MAX    = 1024,
  parameter int PAIRS_MAX  = 64,
  parameter int TREE_MAX   = 64,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic                         cfg_index,
  input  wire logic [10:0]                  cfg_data,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic [1:0]                   cmd,
  input  wire logic [5:0]                   token_index,
  input  wire logic [5:0]                   ancestor_index,
  input  wire logic                         tree_mode,
  input  wire logic [5:0]                   pair_index,
  input  wire logic signed [DATA_WIDTH-1:0] first_value,
  input  wire logic signed [DATA_WIDTH-1:0] second_value,
  input  wire logic [9:0]                   table_position,
  input  wire logic signed [15:0]           sin_word,
  input  wire logic signed [15:0]           cos_word,
  input  wire logic [6:0]                   sequence_length,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic signed [DATA_WIDTH-1:0]      rotated_first,
  output logic signed [DATA_WIDTH-1:0]      rotated_second,
  output logic [9:0]                        position,
  output logic                              position_error
);
  import trope_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int PW   = $clog2(POS_MAX);
  localparam int PAW  = $clog2(PAIRS_MAX);
  localparam int TW   = $clog2(TREE_MAX);
  localparam int CW   = ((PW > MAXPOS_W) ? PW : MAXPOS_W) + 1;
  localparam int IW   = ((TW > 6) ? TW : 6) + 1;
  localparam int PIW  = ((PAW > PAIRS_W) ? PAW : PAIRS_W) + 1;
  localparam int RIW  = ((PW > OUTPOS_W) ? PW : OUTPOS_W) + 1;
  localparam int TAW  = PW + PAW;
  localparam int TD   = POS_MAX * (2 ** PAW);
  localparam int MW   = DW + TRIG_W;
  localparam int SUMW = DW + TRIG_W + 1;
  localparam logic signed [SUMW-1:0] QMAX = {{18{1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] QMIN = {{18{1'b1}}, {(DW-1){1'b0}}};
  localparam logic [PW-1:0] POS_TOP = PW'(POS_MAX - 1);

  // configuration and architectural state
  logic [PAIRS_W-1:0]  rotary_pairs;
  logic [MAXPOS_W-1:0] max_positions;
  logic [PW-1:0]       base_position;
  logic [PW-1:0]       token_position;
  logic                token_overflow;

  logic [2*TRIG_W-1:0] sincos_mem [0:TD-1];
  logic [PW-1:0]       tree_mem   [0:TREE_MAX-1];

  // stage 1: decode and state update
  logic                s1_valid;
  cmd_t                s1_cmd;
  logic [5:0]          s1_tok;
  logic                s1_tree;
  logic [5:0]          s1_pair;
  logic signed [DW-1:0] s1_x, s1_y;
  logic [9:0]          s1_row;
  logic [15:0]         s1_sin, s1_cos;
  logic [6:0]          s1_len;
  logic                s1_anc_ok;
  logic                s1_fwd;
  logic [PW-1:0]       s1_fwd_pos;
  logic [PW-1:0]       tree_rd;

  // stage 2: sine/cosine read data
  logic                s2_valid, s2_elem, s2_rot;
  logic signed [DW-1:0] s2_x, s2_y;
  logic [9:0]          s2_pos;
  logic                s2_err;
  logic [2*TRIG_W-1:0] tab_rd;
  logic signed [TRIG_W-1:0] s2_sin, s2_cos;

  // stage 3: products
  logic                s3_valid, s3_elem, s3_rot;
  logic signed [DW-1:0] s3_x, s3_y;
  logic [9:0]          s3_pos;
  logic                s3_err;
  logic signed [MW-1:0] s3_xc, s3_ys, s3_xs, s3_yc;

  // result queue
  logic signed [DW-1:0] q_first  [RSP_DEPTH];
  logic signed [DW-1:0] q_second [RSP_DEPTH];
  logic [9:0]          q_pos    [RSP_DEPTH];
  logic                q_err    [RSP_DEPTH];
  logic [RSP_PW-1:0]   wr_ptr, rd_ptr, pending;

  logic req_take, rsp_take;

  assign req_stall = (pending == RSP_PW'(RSP_DEPTH));
  assign req_take  = req_valid && !req_stall;
  assign rsp_valid = (wr_ptr != rd_ptr);
  assign rsp_take  = rsp_valid && !rsp_stall;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rotary_pairs  <= PAIRS_RST;
      max_positions <= MAXPOS_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROTARY_PAIRS:  rotary_pairs  <= cfg_data[PAIRS_W-1:0];
        REG_MAX_POSITIONS: max_positions <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1 logic ----------------
  logic [IW-1:0]   anc_ext, s1_tok_ext;
  logic            anc_ok, s1_tok_ok;
  logic [TW-1:0]   anc_addr, s1_tok_addr;
  logic [CW-1:0]   limit_c, pos_raw, end_sum;
  logic [PW-1:0]   anc_val, pos_sat;
  logic            pos_ovf;
  logic            tree_we, tab_we, tab_re;
  logic [PIW-1:0]  s1_pair_ext;
  logic [PAW-1:0]  s1_pair_idx;
  logic [RIW-1:0]  s1_row_ext;
  logic            s1_rot;
  logic [PW-1:0]   s1_pos_use;
  logic            s1_err_use;
  logic [RIW-1:0]  s1_pos_wide;
  logic [TAW-1:0]  tab_addr;

  always_comb begin
    anc_ext     = IW'(ancestor_index);
    anc_ok      = anc_ext < IW'(TREE_MAX);
    anc_addr    = anc_ext[TW-1:0];
    s1_tok_ext  = IW'(s1_tok);
    s1_tok_ok   = s1_tok_ext < IW'(TREE_MAX);
    s1_tok_addr = s1_tok_ext[TW-1:0];
    s1_pair_ext = PIW'(s1_pair);
    s1_pair_idx = s1_pair_ext[PAW-1:0];
    s1_row_ext  = RIW'(s1_row);

    limit_c = (CW'(max_positions) < CW'(POS_MAX)) ? CW'(max_positions) : CW'(POS_MAX);
    anc_val = !s1_anc_ok ? '0 : (s1_fwd ? s1_fwd_pos : tree_rd);
    if (s1_tok == 6'd0 || !s1_tree) begin
      pos_raw = CW'(base_position) + CW'(s1_tok);
    end else begin
      pos_raw = CW'(anc_val) + CW'(1);
    end
    pos_ovf = pos_raw >= limit_c;
    pos_sat = (pos_raw > CW'(POS_TOP)) ? POS_TOP : pos_raw[PW-1:0];
    end_sum = CW'(base_position) + CW'(s1_len);

    tree_we    = 1'b0;
    tab_we     = 1'b0;
    tab_re     = 1'b0;
    s1_pos_use = token_position;
    s1_err_use = token_overflow;
    unique case (s1_cmd)
      CMD_TABLE: tab_we = s1_valid && (s1_row_ext < RIW'(POS_MAX))
                          && (s1_pair_ext < PIW'(PAIRS_MAX));
      CMD_TOKEN: begin
        tree_we    = s1_valid && s1_tree && s1_tok_ok;
        s1_pos_use = pos_sat;
        s1_err_use = pos_ovf;
      end
      CMD_ELEM:  tab_re = s1_valid;
      CMD_END:   ;
      default:   ;
    endcase
    s1_rot = (s1_pair_ext < PIW'(rotary_pairs)) && (s1_pair_ext < PIW'(PAIRS_MAX))
             && !token_overflow;
    s1_pos_wide = RIW'(s1_pos_use);
    tab_addr = tab_we ? {s1_row_ext[PW-1:0], s1_pair_idx} : {token_position, s1_pair_idx};
  end

  // capture the request and start the ancestor lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req_take;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_cmd     <= cmd_t'(cmd);
      s1_tok     <= token_index;
      s1_tree    <= tree_mode;
      s1_pair    <= pair_index;
      s1_x       <= first_value;
      s1_y       <= second_value;
      s1_row     <= table_position;
      s1_sin     <= sin_word;
      s1_cos     <= cos_word;
      s1_len     <= sequence_length;
      s1_anc_ok  <= anc_ok;
      // forward a position being written this cycle to the same slot
      s1_fwd     <= tree_we && (s1_tok_addr == anc_addr);
      s1_fwd_pos <= pos_sat;
      tree_rd    <= tree_mem[anc_addr];
    end
    if (tree_we) begin
      tree_mem[s1_tok_addr] <= pos_sat;
    end
  end

  // token and base state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_position  <= '0;
      token_position <= '0;
      token_overflow <= 1'b0;
    end else if (s1_valid) begin
      if (s1_cmd == CMD_TOKEN) begin
        token_position <= pos_sat;
        token_overflow <= pos_ovf;
      end else if (s1_cmd == CMD_END) begin
        base_position <= (end_sum >= limit_c) ? '0 : end_sum[PW-1:0];
      end
    end
  end

  // sine/cosine memory, single port
  always_ff @(posedge clk) begin
    if (tab_we) begin
      sincos_mem[tab_addr] <= {s1_sin, s1_cos};
    end else if (tab_re) begin
      tab_rd <= sincos_mem[tab_addr];
    end
  end

  // ---------------- stage 2 ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_elem <= (s1_cmd == CMD_ELEM);
    s2_rot  <= s1_rot;
    s2_x    <= s1_x;
    s2_y    <= s1_y;
    s2_pos  <= s1_pos_wide[9:0];
    s2_err  <= s1_err_use;
  end

  assign s2_sin = signed'(tab_rd[2*TRIG_W-1:TRIG_W]);
  assign s2_cos = signed'(tab_rd[TRIG_W-1:0]);

  // ---------------- stage 3: multiply ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_elem <= s2_elem;
    s3_rot  <= s2_rot;
    s3_x    <= s2_x;
    s3_y    <= s2_y;
    s3_pos  <= s2_pos;
    s3_err  <= s2_err;
    s3_xc   <= MW'(s2_x) * MW'(s2_cos);
    s3_ys   <= MW'(s2_y) * MW'(s2_sin);
    s3_xs   <= MW'(s2_x) * MW'(s2_sin);
    s3_yc   <= MW'(s2_y) * MW'(s2_cos);
  end

  // round half up at bit 15, then clamp to the data range
  function automatic logic signed [DW-1:0] rnd_sat(input logic signed [SUMW-1:0] acc);
    logic signed [SUMW-1:0] q;
    begin
      q = (acc + SUMW'(16384)) >>> 15;
      if (q > QMAX) begin
        rnd_sat = QMAX[DW-1:0];
      end else if (q < QMIN) begin
        rnd_sat = QMIN[DW-1:0];
      end else begin
        rnd_sat = q[DW-1:0];
      end
    end
  endfunction

  logic signed [SUMW-1:0] sum_first, sum_second;
  logic signed [DW-1:0]   res_first, res_second;

  always_comb begin
    sum_first  = SUMW'(s3_xc) - SUMW'(s3_ys);
    sum_second = SUMW'(s3_xs) + SUMW'(s3_yc);
    if (!s3_elem) begin
      res_first  = '0;
      res_second = '0;
    end else if (s3_rot) begin
      res_first  = rnd_sat(sum_first);
      res_second = rnd_sat(sum_second);
    end else begin
      res_first  = s3_x;
      res_second = s3_y;
    end
  end

  // ---------------- result queue ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      pending <= '0;
    end else begin
      if (s3_valid) begin
        wr_ptr <= wr_ptr + RSP_PW'(1);
      end
      if (rsp_take) begin
        rd_ptr <= rd_ptr + RSP_PW'(1);
      end
      // count requests in flight or queued; hold new requests when full
      if (req_take && !rsp_take) begin
        pending <= pending + RSP_PW'(1);
      end else if (!req_take && rsp_take) begin
        pending <= pending - RSP_PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      q_first[wr_ptr[RSP_AW-1:0]]  <= res_first;
      q_second[wr_ptr[RSP_AW-1:0]] <= res_second;
      q_pos[wr_ptr[RSP_AW-1:0]]    <= s3_pos;
      q_err[wr_ptr[RSP_AW-1:0]]    <= s3_err;
    end
  end

  assign rotated_first  = q_first[rd_ptr[RSP_AW-1:0]];
  assign rotated_second = q_second[rd_ptr[RSP_AW-1:0]];
  assign position       = q_pos[rd_ptr[RSP_AW-1:0]];
  assign position_error = q_err[rd_ptr[RSP_AW-1:0]];

endmodule : tree_rotary_position_embedding
`default_nettype wire
